[hdl/sle_pkg.sv]
// Package: shared types, codes and constants of the sequential list engine.
`default_nettype none
package sle_pkg;
  localparam int CAPACITY_DEFAULT = 64;
  localparam int ELEMENT_BITS_DEFAULT = 32;
  localparam int REQ_W = 4;
  localparam int POS_W = 8;
  localparam int VAL_W = 32;
  localparam int STAT_W = 3;
  localparam int LOC_W = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE  = 4'd0,
    REQ_DESTROY = 4'd1,
    REQ_CLEAR   = 4'd2,
    REQ_GET     = 4'd3,
    REQ_LOCATE  = 4'd4,
    REQ_PRIOR   = 4'd5,
    REQ_NEXT    = 4'd6,
    REQ_INSERT  = 4'd7,
    REQ_DELETE  = 4'd8
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_LIST  = 3'd1,
    ST_BAD_POS  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_NO_NEIGH = 3'd4,
    ST_FULL     = 3'd5,
    ST_EXISTS   = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_RD, S_RDW, S_SCAN_RD, S_SCAN_CHK, S_PEER_LD, S_PEER_RD, S_PEER_WT,
    S_SHUP_RD, S_SHUP_WR, S_SHDN_RD, S_SHDN_WR, S_INS_WR, S_DONE
  } state_t;

  // Datapath commands from the controller.
  typedef struct packed {
    logic load_req;     // capture the request
    logic idx_load;     // idx <= idx_init
    logic [1:0] idx_init; // 0: zero, 1: count, 2: pos-1, 3: last hit
    logic idx_inc;
    logic idx_dec;
    logic rd;           // read at rd_sel
    logic [1:0] rd_sel; // 0: idx, 1: idx-1, 2: idx+1, 3: hold address
    logic wr_shift;     // store read data at idx
    logic wr_val;       // store request value at idx
    logic note_match;   // record idx as a hit
    logic take_vout;    // value_out <= read data
    logic cnt_zero;
    logic cnt_inc;
    logic cnt_dec;
    logic set_created;
    logic clr_created;
    logic set_status;
    logic [STAT_W-1:0] status;
    logic loc_from_idx;
    logic clr_out;
    logic out_valid;
  } cmd_t;

  // Datapath status back to the controller.
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic created;
    logic count_zero;
    logic full;
    logic pos_ok_read;   // 1 <= pos <= count
    logic pos_ok_ins;    // 1 <= pos <= count+1
    logic idx_at_end;    // idx >= count-1 (or count empty)
    logic idx_past;      // idx >= count
    logic idx_at_pos;    // idx == pos-1 or idx == 0 (shift stop)
    logic idx_zero;
    logic match;         // read data equals request value
    logic hit;
    logic hit_first;
    logic hit_last;
    logic out_busy;
  } stat_t;
endpackage
`default_nettype wire

[hdl/sle_if.sv]
// Valid/ready channel interface carrying one item payload.
`default_nettype none
interface sle_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/sequential_list_engine.sv]
// Top level of the sequential list engine.
`default_nettype none
// An array list of up to CAPACITY signed words, one request item in and one
// result item out. Every request runs to completion before the next item is
// accepted. Locate, prior and next walk the element RAM one element at a
// time (read, then compare); insert and delete move each shifted element
// through the RAM with a read and then a write. The result then waits in its
// register until it is taken, and the next item is accepted in the cycle
// after that. The RAM has no reset; only entries below the length held when
// the request began are ever read.
module sequential_list_engine #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEFAULT,
  parameter int ELEMENT_BITS = sle_pkg::ELEMENT_BITS_DEFAULT
) (
  input wire logic clk,
  input wire logic rst,
  sle_if.sink req_ch,
  sle_if.source res_ch
);
  sle_pkg::cmd_t cmd;
  sle_pkg::stat_t st;

  sle_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(req_ch.valid), .in_ready(req_ch.ready),
    .st(st), .cmd(cmd)
  );

  sle_datapath #(.CAPACITY(CAPACITY), .ELEMENT_BITS(ELEMENT_BITS)) u_dp (
    .clk(clk), .rst(rst),
    .in_req(req_ch.data.req_type), .in_pos(req_ch.data.position),
    .in_val(req_ch.data.value),
    .cmd(cmd), .st(st),
    .out_take(res_ch.ready), .out_valid(res_ch.valid),
    .status(res_ch.data.status), .value_out(res_ch.data.value_out),
    .location(res_ch.data.location), .list_length(res_ch.data.list_length),
    .is_empty(res_ch.data.is_empty), .list_exists(res_ch.data.list_exists)
  );
endmodule
`default_nettype wire

[hdl/sle_ram.sv]
// Generic RAM with one write port and one registered read port.
`default_nettype none
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hdl/sle_datapath.sv]
// Datapath: request registers, element RAM, index and count, result register.
`default_nettype none
module sle_datapath #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEFAULT,
  parameter int ELEMENT_BITS = sle_pkg::ELEMENT_BITS_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [sle_pkg::REQ_W-1:0] in_req,
  input  wire logic [sle_pkg::POS_W-1:0] in_pos,
  input  wire logic signed [sle_pkg::VAL_W-1:0] in_val,
  input  wire sle_pkg::cmd_t cmd,
  output sle_pkg::stat_t st,
  input  wire logic out_take,
  output logic out_valid,
  output logic [sle_pkg::STAT_W-1:0] status,
  output logic signed [sle_pkg::VAL_W-1:0] value_out,
  output logic [sle_pkg::LOC_W-1:0] location,
  output logic [sle_pkg::LOC_W-1:0] list_length,
  output logic is_empty,
  output logic list_exists
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  // Wide enough for both the count and the full request position.
  localparam int IW = (CW > sle_pkg::POS_W) ? CW + 1 : sle_pkg::POS_W + 1;

  logic [sle_pkg::REQ_W-1:0] req;
  logic [sle_pkg::POS_W-1:0] pos;
  logic [ELEMENT_BITS-1:0] val;
  logic [CW-1:0] count;
  logic created;
  logic [IW-1:0] idx;
  logic [IW-1:0] hit_idx;
  logic hit;
  logic [AW-1:0] raddr, raddr_q;
  logic [ELEMENT_BITS-1:0] rdata;
  logic we;
  logic [ELEMENT_BITS-1:0] wdata;
  logic [IW-1:0] cnt_x, pos_x, rd_pick;
  logic signed [ELEMENT_BITS+31:0] val_ext;

  assign val_ext = (ELEMENT_BITS+32)'(in_val);
  assign cnt_x = IW'(count);
  assign pos_x = IW'(pos);

  always_comb begin
    unique case (cmd.rd_sel)
      2'd0: rd_pick = idx;
      2'd1: rd_pick = idx - IW'(1);
      2'd2: rd_pick = idx + IW'(1);
      default: rd_pick = IW'(raddr_q);
    endcase
    raddr = cmd.rd ? rd_pick[AW-1:0] : raddr_q;
    we = cmd.wr_shift | cmd.wr_val;
    wdata = cmd.wr_val ? val : rdata;
  end

  sle_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(idx[AW-1:0]), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    raddr_q <= raddr;
    if (cmd.load_req) begin
      req <= in_req;
      pos <= in_pos;
      val <= val_ext[ELEMENT_BITS-1:0];
    end
    if (cmd.idx_load) begin
      unique case (cmd.idx_init)
        2'd0: idx <= '0;
        2'd1: idx <= cnt_x;
        2'd2: idx <= pos_x - IW'(1);
        default: idx <= hit_idx;
      endcase
    end else if (cmd.idx_inc) begin
      idx <= idx + IW'(1);
    end else if (cmd.idx_dec) begin
      idx <= idx - IW'(1);
    end
    if (cmd.note_match) hit_idx <= idx;
    if (cmd.clr_out) begin
      value_out <= '0;
      location <= '0;
    end else begin
      if (cmd.take_vout) value_out <= sle_pkg::VAL_W'(rdata);
      if (cmd.loc_from_idx) location <= sle_pkg::LOC_W'(idx + IW'(1));
    end
    if (cmd.set_status) status <= cmd.status;
    if (cmd.out_valid) begin
      list_length <= sle_pkg::LOC_W'(count);
      is_empty <= (count == '0);
      list_exists <= created;
    end
    if (rst) begin
      count <= '0;
      created <= 1'b0;
      out_valid <= 1'b0;
      hit <= 1'b0;
    end else begin
      if (cmd.cnt_zero) count <= '0;
      else if (cmd.cnt_inc) count <= count + CW'(1);
      else if (cmd.cnt_dec) count <= count - CW'(1);
      if (cmd.set_created) created <= 1'b1;
      else if (cmd.clr_created) created <= 1'b0;
      if (cmd.load_req) hit <= 1'b0;
      else if (cmd.note_match) hit <= 1'b1;
      if (cmd.out_valid) out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
    end
  end

  always_comb begin
    st.req = req;
    st.created = created;
    st.count_zero = (count == '0);
    st.full = (count >= CW'(CAPACITY));
    st.pos_ok_read = (pos_x != '0) && (pos_x <= cnt_x);
    st.pos_ok_ins = (pos_x != '0) && (pos_x <= cnt_x + IW'(1));
    st.idx_at_end = (idx + IW'(1) >= cnt_x);
    st.idx_past = (idx >= cnt_x);
    st.idx_at_pos = (idx + IW'(1) == pos_x) || (idx == '0);
    st.idx_zero = (idx == '0);
    st.match = (rdata == val);
    st.hit = hit;
    st.hit_first = (hit_idx == '0);
    st.hit_last = (hit_idx + IW'(1) == cnt_x);
    st.out_busy = out_valid;
  end

  assert property (@(posedge clk) disable iff (rst) cmd.cnt_inc |-> !st.full)
    else $error("insert into a full list");
  assert property (@(posedge clk) disable iff (rst) cmd.cnt_dec |-> !st.count_zero)
    else $error("delete from an empty list");
  assert property (@(posedge clk) disable iff (rst) !created |-> count == '0)
    else $error("elements present without a list");
endmodule
`default_nettype wire

[hdl/sle_ctrl.sv]
// Controller: sequences each request over the datapath.
`default_nettype none
module sle_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire sle_pkg::stat_t st,
  output sle_pkg::cmd_t cmd
);
  sle_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= sle_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      sle_pkg::S_IDLE: begin
        in_ready = !st.out_busy;
        if (in_valid && !st.out_busy) begin
          cmd.load_req = 1'b1;
          state_next = sle_pkg::S_DECIDE;
        end
      end
      sle_pkg::S_DECIDE: begin
        cmd.clr_out = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status = sle_pkg::ST_OK;
        state_next = sle_pkg::S_DONE;
        if (st.req == sle_pkg::REQ_CREATE) begin
          if (st.created) cmd.status = sle_pkg::ST_EXISTS;
          else begin
            cmd.set_created = 1'b1;
            cmd.cnt_zero = 1'b1;
          end
        end else if (st.req <= sle_pkg::REQ_DELETE && !st.created) begin
          cmd.status = sle_pkg::ST_NO_LIST;
        end else begin
          case (st.req)
            sle_pkg::REQ_DESTROY: begin
              cmd.clr_created = 1'b1;
              cmd.cnt_zero = 1'b1;
            end
            sle_pkg::REQ_CLEAR: cmd.cnt_zero = 1'b1;
            sle_pkg::REQ_GET, sle_pkg::REQ_DELETE: begin
              if (!st.pos_ok_read) cmd.status = sle_pkg::ST_BAD_POS;
              else begin
                cmd.idx_load = 1'b1;
                cmd.idx_init = 2'd2;
                state_next = sle_pkg::S_RD;
              end
            end
            sle_pkg::REQ_LOCATE, sle_pkg::REQ_PRIOR, sle_pkg::REQ_NEXT: begin
              cmd.status = sle_pkg::ST_NOTFOUND;
              cmd.idx_load = 1'b1;
              cmd.idx_init = 2'd0;
              if (!st.count_zero) state_next = sle_pkg::S_SCAN_RD;
            end
            sle_pkg::REQ_INSERT: begin
              if (st.full) cmd.status = sle_pkg::ST_FULL;
              else if (!st.pos_ok_ins) cmd.status = sle_pkg::ST_BAD_POS;
              else begin
                cmd.idx_load = 1'b1;
                cmd.idx_init = 2'd1;
                state_next = sle_pkg::S_SHUP_RD;
              end
            end
            default: ;
          endcase
        end
      end
      sle_pkg::S_RD: begin
        cmd.rd = 1'b1;
        state_next = sle_pkg::S_RDW;
      end
      sle_pkg::S_RDW: begin
        cmd.take_vout = 1'b1;
        if (st.req == sle_pkg::REQ_DELETE) begin
          cmd.cnt_dec = 1'b1;
          state_next = sle_pkg::S_SHDN_RD;
        end else state_next = sle_pkg::S_DONE;
      end
      // Scan: one read per element, compare when the data returns.
      sle_pkg::S_SCAN_RD: begin
        cmd.rd = 1'b1;
        state_next = sle_pkg::S_SCAN_CHK;
      end
      sle_pkg::S_SCAN_CHK: begin
        if (st.match) cmd.note_match = 1'b1;
        if (st.match && st.req == sle_pkg::REQ_LOCATE) begin
          cmd.set_status = 1'b1;
          cmd.status = sle_pkg::ST_OK;
          cmd.loc_from_idx = 1'b1;
          state_next = sle_pkg::S_DONE;
        end else if (st.match && st.req == sle_pkg::REQ_PRIOR && st.idx_zero) begin
          cmd.set_status = 1'b1;
          cmd.status = sle_pkg::ST_NO_NEIGH;
          state_next = sle_pkg::S_DONE;
        end else if (st.match && st.req == sle_pkg::REQ_NEXT && st.idx_at_end) begin
          cmd.set_status = 1'b1;
          cmd.status = sle_pkg::ST_NO_NEIGH;
          state_next = sle_pkg::S_DONE;
        end else if (st.idx_at_end) begin
          if (st.req == sle_pkg::REQ_LOCATE) state_next = sle_pkg::S_DONE;
          else if (st.hit || st.match) state_next = sle_pkg::S_PEER_LD;
          else state_next = sle_pkg::S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next = sle_pkg::S_SCAN_RD;
        end
      end
      // The last hit index sits in the datapath; read its neighbor.
      sle_pkg::S_PEER_LD: begin
        cmd.idx_load = 1'b1;
        cmd.idx_init = 2'd3;
        state_next = sle_pkg::S_PEER_RD;
      end
      sle_pkg::S_PEER_RD: begin
        cmd.rd = 1'b1;
        cmd.rd_sel = (st.req == sle_pkg::REQ_PRIOR) ? 2'd1 : 2'd2;
        state_next = sle_pkg::S_PEER_WT;
      end
      sle_pkg::S_PEER_WT: begin
        cmd.take_vout = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status = sle_pkg::ST_OK;
        state_next = sle_pkg::S_DONE;
      end
      // Insert: move entries up from the top down to the position.
      sle_pkg::S_SHUP_RD: begin
        if (st.idx_zero || st.idx_at_pos) begin
          if (st.idx_zero && !st.idx_at_pos) state_next = sle_pkg::S_INS_WR;
          else state_next = sle_pkg::S_INS_WR;
        end else begin
          cmd.rd = 1'b1;
          cmd.rd_sel = 2'd1;
          state_next = sle_pkg::S_SHUP_WR;
        end
      end
      sle_pkg::S_SHUP_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_dec = 1'b1;
        state_next = sle_pkg::S_SHUP_RD;
      end
      sle_pkg::S_INS_WR: begin
        cmd.wr_val = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_next = sle_pkg::S_DONE;
      end
      // Delete: move entries down; count is already reduced.
      sle_pkg::S_SHDN_RD: begin
        if (st.idx_past) state_next = sle_pkg::S_DONE;
        else begin
          cmd.rd = 1'b1;
          cmd.rd_sel = 2'd2;
          state_next = sle_pkg::S_SHDN_WR;
        end
      end
      sle_pkg::S_SHDN_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next = sle_pkg::S_SHDN_RD;
      end
      sle_pkg::S_DONE: begin
        cmd.out_valid = 1'b1;
        state_next = sle_pkg::S_IDLE;
      end
      default: state_next = sle_pkg::S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.wr_shift |-> $past(cmd.rd))
    else $error("shift write without a read");
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_valid |=> state == sle_pkg::S_IDLE)
    else $error("result issued outside completion");
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == sle_pkg::S_DECIDE)
    else $error("accepted item not decoded");
endmodule
`default_nettype wire
